// File: design/peq_pkg.sv
package peq_pkg;

  // Default structure sizes
  localparam int BANDS_DEF            = 10;
  localparam int CHANNELS_DEF         = 8;
  localparam int FRAMES_PER_BLOCK_DEF = 32;

  // Coefficients per band and their slots
  localparam int NCOEF   = 5;
  localparam int C_B0    = 0;
  localparam int C_B1    = 1;
  localparam int C_B2    = 2;
  localparam int C_A1    = 3;
  localparam int C_A2    = 4;
  localparam int EN_BITS = 10;

  // Configuration register indexes
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [2:0] REG_BAND_ENABLE   = 3'd1;
  localparam logic [2:0] REG_PREAMP_TARGET = 3'd2;
  localparam logic [2:0] REG_SMOOTH_ALPHA  = 3'd3;

  // Input modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  // Reset values
  localparam logic [3:0]  CC_RST    = 4'd2;
  localparam logic [9:0]  BEN_RST   = 10'h3FF;
  localparam logic [23:0] GAIN_ONE  = 24'd1048576;
  localparam logic [15:0] ALPHA_RST = 16'd2336;

  typedef logic signed [47:0] acc_t;
  typedef logic signed [65:0] prod_t;

  // Round a Q4.28 coefficient product back to sample units
  function automatic acc_t rnd28_f(input prod_t p);
    prod_t t;
    t = (p + 66'sd134217728) >>> 28;
    return t[47:0];
  endfunction

  function automatic logic signed [31:0] sat32_f(input acc_t v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [39:0] sat40_f(input acc_t v);
    logic signed [39:0] r;
    if (v > 48'sd549755813887) r = 40'sh7FFFFFFFFF;
    else if (v < -48'sd549755813888) r = 40'sh8000000000;
    else r = v[39:0];
    return r;
  endfunction

  // Saturate to 24 bits; top bit reports the clip
  function automatic logic [24:0] sat24_f(input logic signed [31:0] v);
    logic [24:0] r;
    if (v > 32'sd8388607) r = {1'b1, 24'h7FFFFF};
    else if (v < -32'sd8388608) r = {1'b1, 24'h800000};
    else r = {1'b0, v[23:0]};
    return r;
  endfunction

endpackage

// File: design/peq_if.sv
interface peq_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [2:0]         channel;
  logic signed [23:0] sample_in;
  logic [3:0]         band_select;
  logic [2:0]         coef_select;
  logic signed [31:0] coef_value;
  modport source (output valid, mode, channel, sample_in, band_select, coef_select,
                  coef_value, input ready);
  modport sink (input valid, mode, channel, sample_in, band_select, coef_select,
                coef_value, output ready);
endinterface

interface peq_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_out;
  logic [2:0]         channel_out;
  logic               clipped;
  modport source (output valid, sample_out, channel_out, clipped, input ready);
  modport sink (input valid, sample_out, channel_out, clipped, output ready);
endinterface

interface peq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/peq_ram.sv
module peq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: design/peq_mul.sv
module peq_mul (
  input  logic                 clk,
  input  logic signed [32:0]   a,
  input  logic signed [32:0]   b,
  output peq_pkg::prod_t       p_r
);
  import peq_pkg::*;

  // Shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    p_r <= 66'(a) * 66'(b);
  end

endmodule

// File: design/parametric_eq_biquad_cascade.sv
// Multichannel parametric equalizer, cascade of biquad sections (TDF-II).
// in_ch carries one transaction per item: mode 1 writes one coefficient of one
// band (no result), mode 0 delivers one Q1.23 sample for a channel. Samples
// whose channel is not below the effective channel count are dropped.
// out_ch returns one saturated sample per sample that is not dropped, with its channel
// and a clip flag. cfg_ch writes the four control registers; it is always
// ready and must only be used while the block is idle.
// Sequence per sample: a gain step (states P0, P1) when one is due at a
// block start, the preamp multiply (G0, G1), states B0 to B6 for each enabled
// band, only B0 for a disabled band, and DONE to load the output register.
// The next item is accepted in the cycle after the result loads, so a sample
// is finished before the next one is taken.
// The shared multiplier and the single read port of the coefficient RAM
// serialize these steps. A coefficient write leaves the sequencer idle.
// The next item is accepted while a result waits in the output register; a
// stalled receiver holds the following sample at its final step.
// Reset clears delay state (per-entry valid bits), gain, block position and
// control registers; coefficients are undefined until written.
module parametric_eq_biquad_cascade #(
  parameter int BANDS            = peq_pkg::BANDS_DEF,
  parameter int CHANNELS         = peq_pkg::CHANNELS_DEF,
  parameter int FRAMES_PER_BLOCK = peq_pkg::FRAMES_PER_BLOCK_DEF
) (
  input logic      clk,
  input logic      rst_n,
  peq_in_if.sink   in_ch,
  peq_out_if.source out_ch,
  peq_cfg_if.sink  cfg_ch
);
  import peq_pkg::*;

  localparam int NCF = BANDS * NCOEF;
  localparam int NDL = BANDS * CHANNELS;
  localparam int CAW = (NCF > 1) ? $clog2(NCF) : 1;
  localparam int KW  = (NDL > 1) ? $clog2(NDL) : 1;
  localparam int BW  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int PW  = $clog2(FRAMES_PER_BLOCK + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P0   = 4'd1;
  localparam logic [3:0] S_P1   = 4'd2;
  localparam logic [3:0] S_G0   = 4'd3;
  localparam logic [3:0] S_G1   = 4'd4;
  localparam logic [3:0] S_B0   = 4'd5;
  localparam logic [3:0] S_B1   = 4'd6;
  localparam logic [3:0] S_B2   = 4'd7;
  localparam logic [3:0] S_B3   = 4'd8;
  localparam logic [3:0] S_B4   = 4'd9;
  localparam logic [3:0] S_B5   = 4'd10;
  localparam logic [3:0] S_B6   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  cc_r;
  logic [9:0]  ben_r;
  logic [23:0] target_r;
  logic [15:0] alpha_r;
  logic [23:0] gain_r;
  logic [PW-1:0] pos_r;
  logic        step_due_r;
  logic [NDL-1:0] dvalid_r;
  logic [2:0]  ch_r;
  logic        last_r;
  logic signed [23:0] smp_r;
  logic [BW-1:0] band_r;
  logic signed [31:0] x_r, y_r;
  acc_t        acc_r;
  logic signed [39:0] s1n_r;
  logic        out_valid_r;
  logic signed [23:0] out_smp_r;
  logic [2:0]  out_ch_r;
  logic        out_clip_r;

  logic [4:0]  cc_eff;
  logic        in_acc, out_load;
  logic [BANDS-1:0] en_vec;
  logic [CAW-1:0] cbase, craddr, cwaddr;
  logic        cwe;
  logic [31:0] crdata;
  logic [KW-1:0] kaddr;
  logic [39:0] s1_rd, s2_rd;
  acc_t        s1_x, s2_x;
  logic signed [39:0] s2n;
  logic        dwe;
  logic signed [32:0] mul_a, mul_b;
  prod_t       prod_r;
  acc_t        pre_d;
  logic signed [27:0] g_sum;
  logic [24:0] sat_out;

  // Effective channel count and per-band enables
  always_comb begin
    if (cc_r == 4'd0) cc_eff = 5'd1;
    else if (32'(cc_r) > CHANNELS) cc_eff = 5'(CHANNELS);
    else cc_eff = {1'b0, cc_r};
    for (int b = 0; b < BANDS; b++) begin
      en_vec[b] = (b < EN_BITS) ? ben_r[b % EN_BITS] : 1'b0;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Coefficient RAM: write on accepted coefficient transactions
  assign cwe = in_acc && (in_ch.mode == MODE_COEF) && (32'(in_ch.band_select) < BANDS)
               && (32'(in_ch.coef_select) < NCOEF);
  assign cwaddr = CAW'(32'(in_ch.band_select) * NCOEF + 32'(in_ch.coef_select));
  assign cbase  = CAW'(32'(band_r) * NCOEF);

  // Coefficient read order: b0, b1, a1, b2, a2
  always_comb begin
    case (state_r)
      S_B1:    craddr = cbase + CAW'(C_B1);
      S_B2:    craddr = cbase + CAW'(C_A1);
      S_B3:    craddr = cbase + CAW'(C_B2);
      S_B4:    craddr = cbase + CAW'(C_A2);
      default: craddr = cbase + CAW'(C_B0);
    endcase
  end

  peq_ram #(.WIDTH(32), .DEPTH(NCF)) u_coef (
    .clk(clk), .we(cwe), .waddr(cwaddr), .wdata(in_ch.coef_value),
    .raddr(craddr), .rdata(crdata)
  );

  // Delay RAMs, addressed by band and channel
  assign kaddr = KW'(32'(band_r) * CHANNELS + 32'(ch_r));
  assign dwe   = (state_r == S_B6);

  peq_ram #(.WIDTH(40), .DEPTH(NDL)) u_dly1 (
    .clk(clk), .we(dwe), .waddr(kaddr), .wdata(s1n_r), .raddr(kaddr), .rdata(s1_rd)
  );
  peq_ram #(.WIDTH(40), .DEPTH(NDL)) u_dly2 (
    .clk(clk), .we(dwe), .waddr(kaddr), .wdata(s2n), .raddr(kaddr), .rdata(s2_rd)
  );

  assign s1_x = dvalid_r[kaddr] ? {{8{s1_rd[39]}}, s1_rd} : '0;
  assign s2_x = dvalid_r[kaddr] ? {{8{s2_rd[39]}}, s2_rd} : '0;
  assign s2n  = sat40_f(acc_r - rnd28_f(prod_r));

  // Multiplier operand selection
  always_comb begin
    case (state_r)
      S_P0: begin
        mul_a = {17'b0, alpha_r};
        mul_b = 33'({1'b0, target_r}) - 33'({1'b0, gain_r});
      end
      S_G0: begin
        mul_a = {{9{smp_r[23]}}, smp_r};
        mul_b = {9'b0, gain_r};
      end
      S_B3, S_B5: begin
        mul_a = {crdata[31], crdata};
        mul_b = {y_r[31], y_r};
      end
      default: begin
        mul_a = {crdata[31], crdata};
        mul_b = {x_r[31], x_r};
      end
    endcase
  end

  peq_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod_r));

  // Preamp step arithmetic
  always_comb begin
    pre_d = 48'((prod_r + 66'sd32768) >>> 16);
    g_sum = 28'({1'b0, gain_r}) + pre_d[27:0];
  end

  assign sat_out = sat24_f(x_r);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.mode == MODE_SAMPLE && {2'b0, in_ch.channel} < cc_eff) begin
          state_nxt = step_due_r ? S_P0 : S_G0;
        end
      end
      S_P0: state_nxt = S_P1;
      S_P1: state_nxt = S_G0;
      S_G0: state_nxt = S_G1;
      S_G1: state_nxt = S_B0;
      S_B0: begin
        if (en_vec[band_r]) state_nxt = S_B1;
        else if (32'(band_r) == BANDS - 1) state_nxt = S_DONE;
      end
      S_B1: state_nxt = S_B2;
      S_B2: state_nxt = S_B3;
      S_B3: state_nxt = S_B4;
      S_B4: state_nxt = S_B5;
      S_B5: state_nxt = S_B6;
      S_B6: state_nxt = (32'(band_r) == BANDS - 1) ? S_DONE : S_B0;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cc_r        <= CC_RST;
      ben_r       <= BEN_RST;
      target_r    <= GAIN_ONE;
      alpha_r     <= ALPHA_RST;
      gain_r      <= GAIN_ONE;
      pos_r       <= '0;
      step_due_r  <= 1'b1;
      dvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_CHANNEL_COUNT: cc_r     <= cfg_ch.data[3:0];
          REG_BAND_ENABLE:   ben_r    <= cfg_ch.data[9:0];
          REG_PREAMP_TARGET: target_r <= cfg_ch.data[23:0];
          REG_SMOOTH_ALPHA:  alpha_r  <= cfg_ch.data[15:0];
          default: ;
        endcase
      end
      // Clamp the stepped gain to its unsigned range
      if (state_r == S_P1) begin
        step_due_r <= 1'b0;
        if (g_sum < 0) gain_r <= '0;
        else if (g_sum > 28'sd16777215) gain_r <= 24'hFFFFFF;
        else gain_r <= g_sum[23:0];
      end
      if (dwe) dvalid_r[kaddr] <= 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          if (32'(pos_r) + 1 >= FRAMES_PER_BLOCK) begin
            pos_r      <= '0;
            step_due_r <= 1'b1;
          end else begin
            pos_r <= pos_r + PW'(1);
          end
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r   <= in_ch.channel;
      smp_r  <= in_ch.sample_in;
      last_r <= ({2'b0, in_ch.channel} == cc_eff - 5'd1);
      band_r <= '0;
    end
    case (state_r)
      S_G1: x_r <= sat32_f(48'((prod_r + 66'sd524288) >>> 20));
      S_B0: if (!en_vec[band_r] && 32'(band_r) != BANDS - 1) band_r <= band_r + BW'(1);
      S_B2: y_r <= sat32_f(rnd28_f(prod_r) + s1_x);
      S_B3: acc_r <= rnd28_f(prod_r);
      S_B4: acc_r <= acc_r - rnd28_f(prod_r);
      S_B5: begin
        s1n_r <= sat40_f(acc_r + s2_x);
        acc_r <= rnd28_f(prod_r);
      end
      S_B6: begin
        x_r <= y_r;
        if (32'(band_r) != BANDS - 1) band_r <= band_r + BW'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      out_smp_r  <= sat_out[23:0];
      out_clip_r <= sat_out[24];
      out_ch_r   <= ch_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_out  = out_smp_r;
  assign out_ch.channel_out = out_ch_r;
  assign out_ch.clipped     = out_clip_r;

  // A coefficient write leaves the sequencer idle
  a_coef_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.mode == MODE_COEF) |=> state_r == S_IDLE)
    else $error("sequencer left idle on coefficient write");

  // A new result only comes from the final step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !$past(out_ch.valid)) |-> $past(state_r) == S_DONE)
    else $error("result appeared outside final step");

  // The pending gain step is consumed only by the preamp update
  a_step_use: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(step_due_r) |-> $past(state_r) == S_P1)
    else $error("gain step cleared outside preamp update");

  // Delay state is written only for an enabled band
  a_dly_en: assert property (@(posedge clk) disable iff (!rst_n)
    dwe |-> en_vec[band_r])
    else $error("delay write for disabled band");

endmodule
